/* src/vfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_pkg
// Shared types and constants of the vector queue with running mean.
// ----------------------------------------------------------------------------
package vfm_pkg;

  localparam int OP_WIDTH     = 2;
  localparam int STATUS_WIDTH = 2;
  localparam int OCC_WIDTH    = 5;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_AVG  = 2'd2,
    OP_LIST = 2'd3
  } op_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

/* src/vfm_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_store
// Entry memory of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vfm_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/vfm_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_divider
// Shared signed-by-unsigned divider, one quotient bit per cycle, restoring.
// Quotient is truncated toward zero.
// ----------------------------------------------------------------------------
module vfm_divider #(
  parameter int DIVIDEND_WIDTH = 21,
  parameter int DIVISOR_WIDTH  = 5,
  parameter int QUOT_WIDTH     = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIVIDEND_WIDTH-1:0] dividend_i,
  input  logic [DIVISOR_WIDTH-1:0]  divisor_i,
  output logic                      done_o,
  output logic [QUOT_WIDTH-1:0]     quotient_o
);

  localparam int StepWidth = $clog2(DIVIDEND_WIDTH + 1);

  logic [StepWidth-1:0]      step_q;
  logic                      done_q;
  logic [DIVISOR_WIDTH-1:0]  rem_q;
  logic [DIVIDEND_WIDTH-1:0] quo_q;
  logic [DIVISOR_WIDTH-1:0]  div_q;
  logic                      neg_q;

  logic [DIVIDEND_WIDTH-1:0] magnitude;
  logic [DIVISOR_WIDTH:0]    rem_shift;
  logic [DIVISOR_WIDTH:0]    rem_diff;
  logic                      rem_ge;
  logic [DIVIDEND_WIDTH-1:0] quo_signed;

  assign magnitude = dividend_i[DIVIDEND_WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign rem_shift = {rem_q, quo_q[DIVIDEND_WIDTH-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_q};
  assign rem_diff  = rem_shift - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= StepWidth'(DIVIDEND_WIDTH);
      end else if (step_q != '0) begin
        step_q <= step_q - 1'b1;
        done_q <= (step_q == StepWidth'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= magnitude;
      div_q <= divisor_i;
      neg_q <= dividend_i[DIVIDEND_WIDTH-1];
    end else if (step_q != '0) begin
      rem_q <= rem_ge ? rem_diff[DIVISOR_WIDTH-1:0] : rem_shift[DIVISOR_WIDTH-1:0];
      quo_q <= {quo_q[DIVIDEND_WIDTH-2:0], rem_ge};
    end
  end

  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = quo_signed[QUOT_WIDTH-1:0];
  assign done_o     = done_q;

endmodule

/* src/vector_fifo_with_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_fifo_with_mean
// Bounded queue of three-coordinate signed vectors with a running mean.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries an op and a vector: push,
// pop, average or list. Output channel (out_valid_o/out_ready_i) returns
// status, a vector, the occupancy after the op and a last flag.
// One op is worked at a time; in_ready_o is high only while idle.
// Steps from input transfer to the first result registered at the output:
//   push, empty ops     the execute state loads the result
//   pop                 one memory read, then the result
//   list                one memory read before each entry, entries given
//                       oldest first, last on the final
//   average             the shared bit-serial divider runs once per
//                       coordinate, then the mean vector is loaded.
// The next op is taken as soon as the final result sits in the output
// register, even while the receiver stalls it. A stalled receiver freezes the
// sequencer before each further result. Reset empties the queue and clears
// the sums; the entry memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module vector_fifo_with_mean
  import vfm_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [OP_WIDTH-1:0]           op_i,
  input  logic signed [COORD_WIDTH-1:0] in_x_i,
  input  logic signed [COORD_WIDTH-1:0] in_y_i,
  input  logic signed [COORD_WIDTH-1:0] in_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [STATUS_WIDTH-1:0]       status_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic [OCC_WIDTH-1:0]          occupancy_o,
  output logic                          last_o
);

  localparam int CntWidth  = $clog2(DEPTH + 1);
  localparam int IdxWidth  = $clog2(DEPTH);
  localparam int SumWidth  = COORD_WIDTH + CntWidth;
  localparam int WordWidth = 3 * COORD_WIDTH;
  localparam logic [1:0] CoordX = 2'd0;
  localparam logic [1:0] CoordY = 2'd1;
  localparam logic [1:0] CoordZ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_LIST_RD,
    ST_LIST_OUT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_AVG_OUT
  } state_e;

  function automatic logic [SumWidth-1:0] sext(input logic [COORD_WIDTH-1:0] v);
    return {{CntWidth{v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic logic [IdxWidth-1:0] next_slot(input logic [IdxWidth-1:0] i);
    return (i == IdxWidth'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  state_e                 state_q;
  logic [IdxWidth-1:0]    head_q, tail_q, walk_idx_q;
  logic [CntWidth-1:0]    count_q, walk_cnt_q;
  logic [SumWidth-1:0]    sum_x_q, sum_y_q, sum_z_q;
  logic [1:0]             coord_q;
  op_e                    op_q;
  logic [COORD_WIDTH-1:0] x_q, y_q, z_q;
  logic [COORD_WIDTH-1:0] mean_x_q, mean_y_q, mean_z_q;

  logic                   out_valid_q, last_q;
  status_e                status_q;
  logic [COORD_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
  logic [OCC_WIDTH-1:0]   occ_q;

  logic                   can_load, full, empty, walk_last, in_xfer;
  logic                   emit_en, emit_last;
  status_e                emit_status;
  logic [COORD_WIDTH-1:0] emit_x, emit_y, emit_z;
  logic [CntWidth-1:0]    emit_occ;

  logic                   rd_en, wr_en;
  logic [IdxWidth-1:0]    rd_addr;
  logic [WordWidth-1:0]   rd_data;
  logic [COORD_WIDTH-1:0] rd_x, rd_y, rd_z;

  logic                   div_start, div_done;
  logic [SumWidth-1:0]    div_dividend;
  logic [COORD_WIDTH-1:0] div_quot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign can_load   = !out_valid_q || out_ready_i;
  assign full       = (count_q == CntWidth'(DEPTH));
  assign empty      = (count_q == '0);
  assign walk_last  = (walk_cnt_q == count_q - 1'b1);

  assign rd_x = rd_data[WordWidth-1 -: COORD_WIDTH];
  assign rd_y = rd_data[2*COORD_WIDTH-1 -: COORD_WIDTH];
  assign rd_z = rd_data[COORD_WIDTH-1:0];

  assign wr_en   = (state_q == ST_EXEC) && (op_q == OP_PUSH) && !full && can_load;
  assign rd_en   = ((state_q == ST_EXEC) && (op_q == OP_POP) && !empty) ||
                   (state_q == ST_LIST_RD);
  assign rd_addr = (state_q == ST_LIST_RD) ? walk_idx_q : head_q;

  vfm_store #(
    .DEPTH (DEPTH),
    .WIDTH (WordWidth)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail_q),
    .wr_data_i ({x_q, y_q, z_q}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign div_start = (state_q == ST_DIV_GO);

  always_comb begin
    unique case (coord_q)
      CoordX:  div_dividend = sum_x_q;
      CoordY:  div_dividend = sum_y_q;
      default: div_dividend = sum_z_q;
    endcase
  end

  vfm_divider #(
    .DIVIDEND_WIDTH (SumWidth),
    .DIVISOR_WIDTH  (CntWidth),
    .QUOT_WIDTH     (COORD_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Result selection for the output register.
  always_comb begin
    emit_en     = 1'b0;
    emit_status = STATUS_OK;
    emit_x      = '0;
    emit_y      = '0;
    emit_z      = '0;
    emit_occ    = count_q;
    emit_last   = 1'b1;
    unique case (state_q)
      ST_EXEC: begin
        if (op_q == OP_PUSH) begin
          emit_en = can_load;
          if (full) begin
            emit_status = STATUS_FULL;
          end else begin
            emit_occ = count_q + 1'b1;
          end
        end else if (empty) begin
          emit_en     = can_load;
          emit_status = STATUS_EMPTY;
        end
      end
      ST_POP: begin
        emit_en  = can_load;
        emit_x   = rd_x;
        emit_y   = rd_y;
        emit_z   = rd_z;
        emit_occ = count_q - 1'b1;
      end
      ST_LIST_OUT: begin
        emit_en   = can_load;
        emit_x    = rd_x;
        emit_y    = rd_y;
        emit_z    = rd_z;
        emit_last = walk_last;
      end
      ST_AVG_OUT: begin
        emit_en = can_load;
        emit_x  = mean_x_q;
        emit_y  = mean_y_q;
        emit_z  = mean_z_q;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      walk_idx_q  <= '0;
      walk_cnt_q  <= '0;
      coord_q     <= CoordX;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
      occ_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_en) begin
        out_valid_q <= 1'b1;
        status_q    <= emit_status;
        out_x_q     <= emit_x;
        out_y_q     <= emit_y;
        out_z_q     <= emit_z;
        occ_q       <= OCC_WIDTH'(emit_occ);
        last_q      <= emit_last;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          priority if (op_q == OP_PUSH || empty) begin
            if (emit_en) begin
              state_q <= ST_IDLE;
              if (wr_en) begin
                tail_q  <= next_slot(tail_q);
                count_q <= count_q + 1'b1;
                sum_x_q <= sum_x_q + sext(x_q);
                sum_y_q <= sum_y_q + sext(y_q);
                sum_z_q <= sum_z_q + sext(z_q);
              end
            end
          end else if (op_q == OP_POP) begin
            state_q <= ST_POP;
          end else if (op_q == OP_AVG) begin
            coord_q <= CoordX;
            state_q <= ST_DIV_GO;
          end else begin
            walk_idx_q <= head_q;
            walk_cnt_q <= '0;
            state_q    <= ST_LIST_RD;
          end
        end
        ST_POP: begin
          if (emit_en) begin
            head_q  <= next_slot(head_q);
            count_q <= count_q - 1'b1;
            sum_x_q <= sum_x_q - sext(rd_x);
            sum_y_q <= sum_y_q - sext(rd_y);
            sum_z_q <= sum_z_q - sext(rd_z);
            state_q <= ST_IDLE;
          end
        end
        ST_LIST_RD: begin
          state_q <= ST_LIST_OUT;
        end
        ST_LIST_OUT: begin
          if (emit_en) begin
            if (walk_last) begin
              state_q <= ST_IDLE;
            end else begin
              walk_idx_q <= next_slot(walk_idx_q);
              walk_cnt_q <= walk_cnt_q + 1'b1;
              state_q    <= ST_LIST_RD;
            end
          end
        end
        ST_DIV_GO: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (coord_q == CoordZ) begin
              state_q <= ST_AVG_OUT;
            end else begin
              coord_q <= coord_q + 1'b1;
              state_q <= ST_DIV_GO;
            end
          end
        end
        ST_AVG_OUT: begin
          if (emit_en) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the op and vector on transfer; collect quotients as they finish.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= op_e'(op_i);
      x_q  <= in_x_i;
      y_q  <= in_y_i;
      z_q  <= in_z_i;
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      unique case (coord_q)
        CoordX:  mean_x_q <= div_quot;
        CoordY:  mean_y_q <= div_quot;
        default: mean_z_q <= div_quot;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign occupancy_o = occ_q;
  assign last_o      = last_q;

endmodule

/* src/vfm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_checker
// Port-level checks of the vector queue, bound to the top level.
// ----------------------------------------------------------------------------
module vfm_checker
  import vfm_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int COORD_WIDTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [OP_WIDTH-1:0]           op_i,
  input logic signed [COORD_WIDTH-1:0] in_x_i,
  input logic signed [COORD_WIDTH-1:0] in_y_i,
  input logic signed [COORD_WIDTH-1:0] in_z_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [STATUS_WIDTH-1:0]       status_o,
  input logic signed [COORD_WIDTH-1:0] out_x_o,
  input logic signed [COORD_WIDTH-1:0] out_y_o,
  input logic signed [COORD_WIDTH-1:0] out_z_o,
  input logic [OCC_WIDTH-1:0]          occupancy_o,
  input logic                          last_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(status_o) && $stable(out_x_o) && $stable(out_y_o) &&
      $stable(out_z_o) && $stable(occupancy_o) && $stable(last_o))
    else $error("stalled result changed");

  // While a list still has entries to deliver, no new op is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready in the middle of a list");

  // An empty report is a single result with a zero vector and no entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |->
      last_o && occupancy_o == '0 && out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("bad empty report");

  // A dropped push reports a single zero result with the queue unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |->
      last_o && occupancy_o == OCC_WIDTH'(DEPTH) &&
      out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("bad full report");

endmodule

bind vector_fifo_with_mean vfm_checker #(
  .DEPTH       (DEPTH),
  .COORD_WIDTH (COORD_WIDTH)
) u_vfm_checker (.*);
